// ===== design/kmcw_pkg.sv =====
// shared types, codes and constants for the keyed multi-client watchdog
`default_nettype none
package kmcw_pkg;

   localparam int SLOTS_DEFAULT = 256;

   // field widths
   localparam int OP_W      = 2;
   localparam int SID_W     = 8;
   localparam int PID_W     = 22;
   localparam int ACK_W     = 32;
   localparam int TMO_W     = 20;
   localparam int PER_W     = 21;
   localparam int SLACK_W   = 16;
   localparam int STAT_W    = 3;
   localparam int CNT_OUT_W = 8;
   localparam int REQ_W     = 88;
   localparam int RSP_W     = 80;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 20;

   // register reset values and key constants
   localparam logic [TMO_W-1:0]   MIN_TIMEOUT_RST = 20'd1000;
   localparam logic [SLACK_W-1:0] SLACK_RST       = 16'd500;
   localparam logic [ACK_W-1:0]   FIRST_ACK       = 32'd42;
   localparam logic [ACK_W-1:0]   ACK_STEP        = 32'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_TIMEOUT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLACK       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SUPERVISE   = 2'd2;

   typedef enum logic [OP_W-1:0] {
      OP_SUBSCRIBE   = 2'd0,
      OP_UNSUBSCRIBE = 2'd1,
      OP_KICK        = 2'd2,
      OP_TICK        = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      STS_OK      = 3'd0,
      STS_SMALL   = 3'd1,
      STS_FULL    = 3'd2,
      STS_REMOVED = 3'd3,
      STS_OWNER   = 3'd4,
      STS_ACK     = 3'd5,
      STS_MISSED  = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_PREP,
      S_RUN,
      S_HOLD
   } state_type;

   // one slot of the client table
   typedef struct packed {
      logic             used;
      logic [PID_W-1:0] owner;
      logic [TMO_W-1:0] base;
      logic [PER_W-1:0] reload;
      logic [PER_W-1:0] cnt;
      logic [ACK_W-1:0] ack;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic clear;
      logic load;
      logic prep;
      logic run;
      logic publish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clr_last;
      logic quick;
      logic fin;
      logic out_free;
   } stat_type;

endpackage
`default_nettype wire

// ===== design/kmcw_ctrl.sv =====
// sequencing state machine: clearing pass, item intake, table walk, result hand-off
`default_nettype none
module kmcw_ctrl
   import kmcw_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_tvalid,
   output logic          req_tready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = stat.quick ? S_HOLD : S_RUN;
         end
         S_RUN: begin
            cmd.run = 1'b1;
            if (stat.fin) state_in = S_HOLD;
         end
         S_HOLD: begin
            if (stat.out_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

endmodule
`default_nettype wire

// ===== design/kmcw_dpath.sv =====
// datapath: client table memory, walk counters, config registers, result registers
`default_nettype none
module kmcw_dpath
   import kmcw_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [REQ_W-1:0]     req_tdata,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [RSP_W-1:0]          rsp_tdata,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata,
   input  wire cmd_type              cmd,
   output stat_type                  stat
);

   localparam int SW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

   // configuration registers
   logic [TMO_W-1:0]   min_tmo_ff;
   logic [SLACK_W-1:0] slack_ff;
   logic               sup_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_tmo_ff <= MIN_TIMEOUT_RST;
         slack_ff   <= SLACK_RST;
         sup_ff     <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MIN_TIMEOUT: min_tmo_ff <= csr_wdata;
            CSR_SLACK:       slack_ff   <= csr_wdata[SLACK_W-1:0];
            CSR_SUPERVISE:   sup_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // item registers
   op_type           op_ff;
   logic [SID_W-1:0] sid_ff;
   logic [PID_W-1:0] pid_ff;
   logic [ACK_W-1:0] ack_ff;
   logic [TMO_W-1:0] tmo_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= op_type'(req_tdata[1:0]);
         sid_ff <= req_tdata[9:2];
         pid_ff <= req_tdata[31:10];
         ack_ff <= req_tdata[63:32];
         tmo_ff <= req_tdata[83:64];
      end
   end

   // table memory, one write and one registered read per cycle
   entry_type mem [SLOTS];
   entry_type rd_data_ff;
   entry_type wr_data;
   logic      wr_en;
   logic [SW-1:0] wr_addr;
   logic [SW-1:0] addr_ff, addr_in, last_ff, last_in, pend_addr_ff;
   logic          issue_ff, issue_in, pend_ff, pend_in, found_ff, found_in;
   logic [CW-1:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[addr_ff];
   end

   // result holding registers
   status_type       res_status_ff, res_status_in;
   logic [SID_W-1:0] res_slot_ff, res_slot_in;
   logic [ACK_W-1:0] res_ack_ff, res_ack_in;
   logic [PID_W-1:0] res_xpid_ff, res_xpid_in;

   // item decode
   logic is_sub, is_chk, is_tick, sub_small, sid_bad, walk_fin;
   logic [PER_W-1:0] tmo_slack, kick_per;
   logic [ACK_W-1:0] kick_ack;

   assign is_sub    = (op_ff == OP_SUBSCRIBE);
   assign is_chk    = (op_ff == OP_UNSUBSCRIBE) || (op_ff == OP_KICK);
   assign is_tick   = (op_ff == OP_TICK);
   assign sub_small = (tmo_ff < min_tmo_ff);
   assign sid_bad   = (32'(sid_ff) >= SLOTS);
   assign tmo_slack = PER_W'(tmo_ff) + PER_W'(slack_ff);
   assign kick_per  = (tmo_ff != '0) ? tmo_slack : PER_W'(rd_data_ff.base);
   assign kick_ack  = rd_data_ff.ack + ACK_STEP;

   assign wr_addr = cmd.clear ? addr_ff : pend_addr_ff;

   assign stat.clr_last = (addr_ff == LAST_SLOT);
   assign stat.quick    = (is_sub && sub_small) || (is_tick && !sup_ff) || (is_chk && sid_bad);
   assign stat.out_free = !rsp_tvalid || rsp_tready;
   assign stat.fin      = walk_fin;

   // walk: issue one read per cycle, evaluate the slot read the cycle before
   always_comb begin
      wr_en         = 1'b0;
      wr_data       = rd_data_ff;
      addr_in       = addr_ff;
      last_in       = last_ff;
      issue_in      = issue_ff;
      pend_in       = 1'b0;
      found_in      = found_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_ack_in    = res_ack_ff;
      res_xpid_in   = res_xpid_ff;
      walk_fin      = 1'b0;

      // clearing pass after reset
      if (cmd.clear) begin
         wr_en   = 1'b1;
         wr_data = '0;
         addr_in = addr_ff + 1'b1;
      end

      // set up the walk range and default result
      if (cmd.prep) begin
         issue_in    = 1'b1;
         found_in    = 1'b0;
         res_ack_in  = '0;
         res_xpid_in = '0;
         res_slot_in = is_chk ? sid_ff : '0;
         if (is_sub) begin
            res_status_in = sub_small ? STS_SMALL : STS_FULL;
            addr_in       = SW'(1);
            last_in       = LAST_SLOT;
         end else if (is_chk) begin
            res_status_in = sid_bad ? STS_REMOVED : STS_OK;
            addr_in       = SW'(sid_ff);
            last_in       = SW'(sid_ff);
         end else begin
            res_status_in = STS_OK;
            addr_in       = '0;
            last_in       = LAST_SLOT;
         end
      end

      if (cmd.run) begin
         // read issue side
         if (issue_ff) begin
            pend_in = 1'b1;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == last_ff) issue_in = 1'b0;
         end
         // evaluate side
         if (pend_ff) begin
            if (is_sub) begin
               if (!rd_data_ff.used) begin
                  wr_en          = 1'b1;
                  wr_data.used   = 1'b1;
                  wr_data.owner  = pid_ff;
                  wr_data.base   = tmo_ff;
                  wr_data.reload = tmo_slack;
                  wr_data.cnt    = tmo_slack;
                  wr_data.ack    = FIRST_ACK;
                  count_in       = count_ff + 1'b1;
                  res_status_in  = STS_OK;
                  res_slot_in    = SID_W'(pend_addr_ff);
                  res_ack_in     = FIRST_ACK;
                  walk_fin       = 1'b1;
               end else if (pend_addr_ff == last_ff) begin
                  walk_fin = 1'b1;
               end
            end else if (is_chk) begin
               walk_fin = 1'b1;
               if (!rd_data_ff.used) begin
                  res_status_in = STS_REMOVED;
               end else if (rd_data_ff.owner != pid_ff) begin
                  res_status_in = STS_OWNER;
               end else if (rd_data_ff.ack != ack_ff) begin
                  res_status_in = STS_ACK;
               end else if (op_ff == OP_UNSUBSCRIBE) begin
                  wr_en        = 1'b1;
                  wr_data.used = 1'b0;
                  count_in     = count_ff - 1'b1;
               end else begin
                  wr_en       = 1'b1;
                  wr_data.ack = kick_ack;
                  res_ack_in  = kick_ack;
                  if (sup_ff) begin
                     wr_data.reload = kick_per;
                     wr_data.cnt    = kick_per;
                  end
               end
            end else begin
               if (pend_addr_ff == last_ff) walk_fin = 1'b1;
               if (rd_data_ff.used) begin
                  wr_en = 1'b1;
                  if (rd_data_ff.cnt <= PER_W'(1)) begin
                     wr_data.cnt = rd_data_ff.reload;
                     if (!found_ff) begin
                        found_in      = 1'b1;
                        res_status_in = STS_MISSED;
                        res_slot_in   = SID_W'(pend_addr_ff);
                        res_xpid_in   = rd_data_ff.owner;
                     end
                  end else begin
                     wr_data.cnt = rd_data_ff.cnt - 1'b1;
                  end
               end
            end
         end
      end
   end

   // walk control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff  <= '0;
         issue_ff <= 1'b0;
         pend_ff  <= 1'b0;
         found_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         addr_ff  <= addr_in;
         issue_ff <= issue_in;
         pend_ff  <= pend_in;
         found_ff <= found_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff       <= last_in;
      pend_addr_ff  <= addr_ff;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_ack_ff    <= res_ack_in;
      res_xpid_ff   <= res_xpid_in;
   end

   // output register
   logic rsp_valid_ff;
   logic [RSP_W-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_data_ff <= {7'd0, CNT_OUT_W'(count_ff), res_xpid_ff, res_ack_ff,
                         res_slot_ff, res_status_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== design/keyed_multi_client_watchdog_unit.sv =====
// top level of the keyed multi-client watchdog: controller plus datapath
//
//  channel  dir  handshake              payload
//  req_     in   req_tvalid/req_tready  req_tdata: op, slot_id, client_pid, ack_code, timeout_ms
//  rsp_     out  rsp_tvalid/rsp_tready  rsp_tdata: status, slot_out, ack_out, expired_pid,
//                                                  active_count
//  csr_     in   csr_we                 csr_index, csr_wdata
//
// One item at a time. Subscribe walks slots 1..SLOTS-1 through the single table read
// port, one slot a cycle, stopping at the first free one; a tick walks all SLOTS slots;
// unsubscribe and kick read only their own slot; rejected items and ticks with
// supervision off go straight to the result without a walk.
// After reset a clearing pass marks every slot free before items are taken. The result
// waits in an output register; a new item is taken meanwhile, and a finished item holds
// only while the previous result is still untaken.
`default_nettype none
module keyed_multi_client_watchdog_unit
   import kmcw_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   // [1:0] op, [9:2] slot_id, [31:10] client_pid, [63:32] ack_code, [83:64] timeout_ms
   input  wire logic [REQ_W-1:0]     req_tdata,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // [2:0] status, [10:3] slot_out, [42:11] ack_out, [64:43] expired_pid,
   // [72:65] active_count
   output logic [RSP_W-1:0]          rsp_tdata,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   kmcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   kmcw_dpath #(
      .SLOTS (SLOTS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat)
   );

   // at most one command per cycle
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear, cmd.load, cmd.prep, cmd.run, cmd.publish}))
      else $error("controller issued overlapping commands");

   // an accepted item closes the intake until its result is out
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second item taken while one is in work");

   // a result is published only into a free output register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_tvalid || rsp_tready))
      else $error("result overwrote an untaken result");

   // a walk never starts during the clearing pass
   a_clear_first: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !req_tready)
      else $error("intake open during clearing pass");

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// self-checking testbench for the keyed multi-client watchdog unit
`default_nettype none
module testbench
   import kmcw_pkg::*;
;

   localparam int  NSLOT     = SLOTS_DEFAULT;
   localparam int  CYC_LIMIT = 3000000;
   localparam int  CHK       = 0;   // table copy updated as items are accepted
   localparam int  GEN       = 1;   // table copy updated as items are queued

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_MIN_TIMEOUT;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   keyed_multi_client_watchdog_unit #(.SLOTS(NSLOT)) DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // two copies of the client table and registers
   bit               slot_busy [2][NSLOT];
   logic [PID_W-1:0] slot_owner[2][NSLOT];
   logic [TMO_W-1:0] slot_base [2][NSLOT];
   logic [PER_W-1:0] slot_per  [2][NSLOT];
   logic [PER_W-1:0] slot_cnt  [2][NSLOT];
   logic [ACK_W-1:0] slot_key  [2][NSLOT];
   logic [7:0]       busy_total[2];
   logic [TMO_W-1:0]   min_tmo[2];
   logic [SLACK_W-1:0] slack  [2];
   bit                 watch_on[2];

   logic [REQ_W-1:0] pend_items[$];
   logic [RSP_W-1:0] expected_rsp[$];
   logic [REQ_W-1:0] held_item;
   int n_queued = 0, n_checked = 0, errors = 0, cycles = 0;
   int burst_left = 0, gap_left = 0, stall_mode = 0, mode_left = 0;

   // advance one table copy by one item and return the response it gives
   function automatic logic [RSP_W-1:0] watchdog_step(int m, logic [REQ_W-1:0] d);
      op_type           op;
      logic [SID_W-1:0] sid;
      logic [PID_W-1:0] pid;
      logic [ACK_W-1:0] key;
      logic [TMO_W-1:0] tmo;
      logic [PER_W-1:0] per;
      status_type       st;
      logic [7:0]       so;
      logic [ACK_W-1:0] ao;
      logic [PID_W-1:0] xp;
      bit               found;
      op  = op_type'(d[1:0]);
      sid = d[9:2];
      pid = d[31:10];
      key = d[63:32];
      tmo = d[83:64];
      st = STS_OK; so = '0; ao = '0; xp = '0; found = 0;
      case (op)
         OP_SUBSCRIBE: begin
            if (tmo < min_tmo[m]) st = STS_SMALL;
            else begin
               st = STS_FULL;
               for (int i = 1; i < NSLOT; i++) begin
                  if (!slot_busy[m][i]) begin
                     slot_busy[m][i]  = 1;
                     slot_owner[m][i] = pid;
                     slot_base[m][i]  = tmo;
                     slot_per[m][i]   = PER_W'(tmo) + PER_W'(slack[m]);
                     slot_cnt[m][i]   = slot_per[m][i];
                     slot_key[m][i]   = FIRST_ACK;
                     busy_total[m]++;
                     st = STS_OK; so = 8'(i); ao = FIRST_ACK;
                     break;
                  end
               end
            end
         end
         OP_UNSUBSCRIBE, OP_KICK: begin
            so = sid;
            if (!slot_busy[m][sid] || sid == 0) st = STS_REMOVED;
            else if (slot_owner[m][sid] != pid) st = STS_OWNER;
            else if (slot_key[m][sid] != key) st = STS_ACK;
            else if (op == OP_UNSUBSCRIBE) begin
               slot_busy[m][sid] = 0;
               if (busy_total[m] > 0) busy_total[m]--;
            end else begin
               per = (tmo != 0) ? PER_W'(tmo) + PER_W'(slack[m]) : PER_W'(slot_base[m][sid]);
               slot_key[m][sid] = slot_key[m][sid] + ACK_STEP;
               ao = slot_key[m][sid];
               if (watch_on[m]) begin
                  slot_per[m][sid] = per;
                  slot_cnt[m][sid] = per;
               end
            end
         end
         default: begin
            if (watch_on[m]) begin
               for (int i = 0; i < NSLOT; i++) begin
                  if (!slot_busy[m][i]) continue;
                  if (slot_cnt[m][i] <= 1) begin
                     slot_cnt[m][i] = slot_per[m][i];
                     if (!found) begin
                        found = 1; st = STS_MISSED; so = 8'(i); xp = slot_owner[m][i];
                     end
                  end else slot_cnt[m][i]--;
               end
            end
         end
      endcase
      return {7'b0, busy_total[m], xp, ao, so, st};
   endfunction

   // queue one item and advance the generator copy
   task automatic queue_item(op_type op, int sid, logic [PID_W-1:0] pid,
                             logic [ACK_W-1:0] key, logic [TMO_W-1:0] tmo);
      logic [REQ_W-1:0] d;
      d = {4'b0, tmo, key, pid, 8'(sid), op};
      void'(watchdog_step(GEN, d));
      pend_items.push_back(d);
      n_queued++;
   endtask

   // one random item, mostly well-formed against the generator copy
   task automatic queue_random(int tmo_max);
      int               pick, s;
      logic [PID_W-1:0] pid;
      logic [ACK_W-1:0] key;
      pick = $urandom_range(0, 99);
      s = 0;
      for (int t = 0; t < 24 && !slot_busy[GEN][s]; t++) s = $urandom_range(1, NSLOT - 1);
      pid = ($urandom_range(0, 3) == 0) ? PID_W'($urandom_range(1, 22'h3FFFFF))
                                       : PID_W'($urandom_range(1, 6));
      if (pick < 10) begin
         // noise: any field value at all
         queue_item(op_type'($urandom_range(0, 3)), $urandom_range(0, 255),
                    PID_W'($urandom_range(1, 22'h3FFFFF)), $urandom, TMO_W'($urandom));
      end else if (pick < 35 || !slot_busy[GEN][s]) begin
         queue_item(OP_SUBSCRIBE, $urandom_range(0, 255), pid, $urandom,
                    TMO_W'($urandom_range(0, tmo_max)));
      end else if (pick < 65) begin
         key = slot_key[GEN][s];
         if ($urandom_range(0, 9) == 0) key = key ^ (32'd1 << $urandom_range(0, 31));
         queue_item(OP_KICK, s, ($urandom_range(0, 9) == 0) ? pid : slot_owner[GEN][s], key,
                    ($urandom_range(0, 3) == 0) ? '0 : TMO_W'($urandom_range(0, tmo_max)));
      end else if (pick < 75) begin
         queue_item(OP_UNSUBSCRIBE, s, ($urandom_range(0, 7) == 0) ? pid : slot_owner[GEN][s],
                    slot_key[GEN][s], TMO_W'($urandom));
      end else begin
         queue_item(OP_TICK, $urandom_range(0, 255), pid, $urandom, TMO_W'($urandom));
      end
   endtask

   // wait until every queued item has its response, then let the block settle
   task automatic drain;
      while (n_checked != n_queued) @(posedge clock);
      repeat (NSLOT + 20) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      for (int m = 0; m < 2; m++) begin
         if (idx == CSR_MIN_TIMEOUT) min_tmo[m] = val;
         else if (idx == CSR_SLACK) slack[m] = val[SLACK_W-1:0];
         else if (idx == CSR_SUPERVISE) watch_on[m] = val[0];
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic setup(int mn, int sl, int sup);
      write_reg(CSR_MIN_TIMEOUT, CSR_DAT_W'(mn));
      write_reg(CSR_SLACK, CSR_DAT_W'(sl));
      write_reg(CSR_SUPERVISE, CSR_DAT_W'(sup));
   endtask

   // sender: bursts of items with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) expected_rsp.push_back(watchdog_step(CHK, held_item));
         if (!(req_tvalid && !req_tready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pend_items.size() > 0) begin
               held_item = pend_items.pop_front();
               req_tdata  <= held_item;
               req_tvalid <= 1'b1;
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = $urandom_range(0, 30);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
         errors++;
      end
   endtask

   // receiver: stall pattern plus response check
   always @(posedge clock) begin
      logic [RSP_W-1:0] e;
      cycles++;
      if (cycles > CYC_LIMIT) begin
         $display("FAIL");
         $finish;
      end
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_left  = $urandom_range(1, 60);
      end else mode_left--;
      rsp_tready <= (stall_mode == 0) ? 1'b1 :
                    (stall_mode == 1) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 7) == 0);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: response with none expected, actual %0h", $time, rsp_tdata);
            errors++;
         end else begin
            e = expected_rsp.pop_front();
            check_field("status", e[2:0], rsp_tdata[2:0]);
            check_field("slot_out", e[10:3], rsp_tdata[10:3]);
            check_field("ack_out", e[42:11], rsp_tdata[42:11]);
            check_field("expired_pid", e[64:43], rsp_tdata[64:43]);
            check_field("active_count", e[72:65], rsp_tdata[72:65]);
            n_checked++;
         end
      end
   end

   initial begin
      for (int m = 0; m < 2; m++) begin
         min_tmo[m] = MIN_TIMEOUT_RST; slack[m] = SLACK_RST; watch_on[m] = 0;
         busy_total[m] = '0;
         for (int i = 0; i < NSLOT; i++) slot_busy[m][i] = 0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, every status but full and missed, reset register values
      queue_item(OP_SUBSCRIBE, 0, 5, 0, 999);
      queue_item(OP_SUBSCRIBE, 255, 5, 32'hFFFFFFFF, 1000);
      queue_item(OP_SUBSCRIBE, 0, 22'h3FFFFF, 0, 20'hFFFFF);
      queue_item(OP_UNSUBSCRIBE, 0, 5, FIRST_ACK, 0);
      queue_item(OP_KICK, 255, 5, FIRST_ACK, 0);
      queue_item(OP_KICK, 1, 6, FIRST_ACK, 0);
      queue_item(OP_KICK, 1, 5, 0, 0);
      queue_item(OP_KICK, 1, 5, FIRST_ACK, 7);
      queue_item(OP_KICK, 1, 5, FIRST_ACK + ACK_STEP, 0);
      queue_item(OP_UNSUBSCRIBE, 2, 22'h3FFFFF, 32'hFFFFFFFF, 0);
      queue_item(OP_UNSUBSCRIBE, 2, 22'h3FFFFF, FIRST_ACK, 20'hFFFFF);
      queue_item(OP_SUBSCRIBE, 0, 1, 0, 20'hFFFFF);
      queue_item(OP_TICK, 255, 22'h3FFFFF, 32'hFFFFFFFF, 20'hFFFFF);
      queue_item(OP_TICK, 0, 1, 0, 0);
      drain();

      // supervision on with tiny timeouts: frequent deadline misses
      setup(0, 0, 1);
      queue_item(OP_KICK, 1, 5, FIRST_ACK + 2 * ACK_STEP, 0);
      repeat (100) queue_random(6);
      drain();

      // largest minimum and slack
      setup(20'hFFFFF, 16'hFFFF, 1);
      repeat (40) queue_random(20'hFFFFF);
      drain();

      // supervision off: kicks advance keys, timers freeze; fill the table
      setup(0, 3, 0);
      repeat (NSLOT + 2) queue_item(OP_SUBSCRIBE, 0, PID_W'($urandom_range(1, 6)), 0,
                                    TMO_W'($urandom_range(0, 4)));
      repeat (30) queue_random(5);
      drain();

      // resume the frozen timers, then mixed traffic
      write_reg(CSR_SUPERVISE, 1);
      repeat (70) queue_random(8);
      drain();
      setup(2, 1, 1);
      repeat (40) queue_random(10);
      drain();

      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
`default_nettype wire

// ===== filelist.f =====
design/kmcw_pkg.sv
design/kmcw_ctrl.sv
design/kmcw_dpath.sv
design/keyed_multi_client_watchdog_unit.sv
bench/testbench.sv
